[rtl/id_free_stack_allocator_core_macros.svh]
// assertion helpers shared by the allocator rtl
`ifndef ID_FREE_STACK_ALLOCATOR_CORE_MACROS_SVH
`define ID_FREE_STACK_ALLOCATOR_CORE_MACROS_SVH

// same-cycle implication, checked out of reset
`define IFSA_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked out of reset
`define IFSA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/ifsa_pkg.sv]
package ifsa_pkg;

  localparam int MAX_ID_DEF = 1023;
  localparam int ID_W       = 16;
  localparam int CMD_W      = 2;
  localparam int ST_W       = 3;

  typedef enum logic [CMD_W-1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_FREE    = 2'd1,
    CMD_RESERVE = 2'd2,
    CMD_NOP     = 2'd3
  } cmd_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK        = 3'd0,
    ST_NONE_FREE = 3'd1,
    ST_RANGE     = 3'd2,
    ST_NOT_FREE  = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  typedef enum logic [2:0] {
    S_INIT,
    S_IDLE,
    S_DEC,
    S_POP,
    S_SCAN,
    S_MOVE,
    S_MOVE_WR
  } state_t;

endpackage

[rtl/id_free_stack_allocator_core.sv]
// channel  dir  handshake            tuser              tdata
// in_      in   in_tvalid/in_tready  [1:0] command      [15:0] id
// out_     out  out_tvalid/out_tready [2:0] status      [15:0] granted_id
//
// after reset a fill pass writes the stack; no word is taken meanwhile
// allocate reads then pops the top slot; free, nop, out-of-range and empty alloc end in decode
// reserve: scans the slots through the single ram read port, then moves the top word into the found slot,
// one word at a time; in_tready drops while a word is at work or a result waits unread
module id_free_stack_allocator_core #(
  parameter int MAX_ID = ifsa_pkg::MAX_ID_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [1:0]  in_tuser,   // [1:0] command
  input  logic [15:0] in_tdata,   // [15:0] id
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [2:0]  out_tuser,  // [2:0] status
  output logic [15:0] out_tdata   // [15:0] granted_id
);

  `include "id_free_stack_allocator_core_macros.svh"

  localparam int AW   = (MAX_ID > 1) ? $clog2(MAX_ID) : 1;
  localparam int CW   = $clog2(MAX_ID + 1);
  localparam int IDW  = ifsa_pkg::ID_W;

  ifsa_pkg::state_t  state_r, state_nxt;
  ifsa_pkg::cmd_t    cmd_r, cmd_nxt;
  logic [IDW-1:0]    id_r, id_nxt;
  logic [CW-1:0]     top_r, top_nxt;
  logic [AW-1:0]     init_r, init_nxt;
  logic [CW-1:0]     idx_r, idx_nxt;
  logic              pend_r, pend_nxt;
  logic [AW-1:0]     pidx_r, pidx_nxt;
  logic [AW-1:0]     found_r, found_nxt;
  logic              out_valid_r, out_valid_nxt;
  ifsa_pkg::status_t status_r, status_nxt;
  logic [IDW-1:0]    grant_r, grant_nxt;

  logic              we, re;
  logic [AW-1:0]     waddr, raddr;
  logic [IDW-1:0]    wdata, rdata;
  logic              fin;
  ifsa_pkg::status_t fin_status;
  logic [IDW-1:0]    fin_grant;
  logic              id_ok;
  logic [AW-1:0]     top_m1;

  ifsa_ram #(
    .DEPTH (MAX_ID),
    .AW    (AW)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .re    (re),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign in_tready  = (state_r == ifsa_pkg::S_IDLE) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;
  assign out_tuser  = status_r;
  assign out_tdata  = grant_r;

  assign id_ok  = (id_r != '0) && (id_r <= IDW'(MAX_ID));
  assign top_m1 = AW'(top_r - CW'(1));

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    id_nxt     = id_r;
    top_nxt    = top_r;
    init_nxt   = init_r;
    idx_nxt    = idx_r;
    pend_nxt   = 1'b0;
    pidx_nxt   = pidx_r;
    found_nxt  = found_r;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    re         = 1'b0;
    raddr      = '0;
    fin        = 1'b0;
    fin_status = ifsa_pkg::ST_OK;
    fin_grant  = '0;
    case (state_r)
      ifsa_pkg::S_INIT: begin
        we    = 1'b1;
        waddr = init_r;
        wdata = IDW'(MAX_ID) - IDW'(init_r);
        if (init_r == AW'(MAX_ID - 1)) begin
          state_nxt = ifsa_pkg::S_IDLE;
        end else begin
          init_nxt = init_r + AW'(1);
        end
      end
      ifsa_pkg::S_IDLE: begin
        if (in_tvalid && in_tready) begin
          cmd_nxt   = ifsa_pkg::cmd_t'(in_tuser);
          id_nxt    = in_tdata;
          idx_nxt   = '0;
          state_nxt = ifsa_pkg::S_DEC;
        end
      end
      ifsa_pkg::S_DEC: begin
        case (cmd_r)
          ifsa_pkg::CMD_ALLOC: begin
            if (top_r == '0) begin
              fin        = 1'b1;
              fin_status = ifsa_pkg::ST_NONE_FREE;
            end else begin
              re        = 1'b1;
              raddr     = top_m1;
              state_nxt = ifsa_pkg::S_POP;
            end
          end
          ifsa_pkg::CMD_FREE: begin
            fin = 1'b1;
            if (!id_ok) begin
              fin_status = ifsa_pkg::ST_RANGE;
            end else if (top_r >= CW'(MAX_ID)) begin
              fin_status = ifsa_pkg::ST_FULL;
            end else begin
              we      = 1'b1;
              waddr   = AW'(top_r);
              wdata   = id_r;
              top_nxt = top_r + CW'(1);
            end
          end
          ifsa_pkg::CMD_RESERVE: begin
            if (!id_ok) begin
              fin        = 1'b1;
              fin_status = ifsa_pkg::ST_RANGE;
            end else begin
              state_nxt = ifsa_pkg::S_SCAN;
            end
          end
          default: begin
            fin = 1'b1;
          end
        endcase
      end
      ifsa_pkg::S_POP: begin
        fin       = 1'b1;
        fin_grant = rdata;
        top_nxt   = top_r - CW'(1);
      end
      ifsa_pkg::S_SCAN: begin
        if (pend_r && (rdata == id_r)) begin
          found_nxt = pidx_r;
          state_nxt = ifsa_pkg::S_MOVE;
        end else if (idx_r < top_r) begin
          re       = 1'b1;
          raddr    = AW'(idx_r);
          idx_nxt  = idx_r + CW'(1);
          pend_nxt = 1'b1;
          pidx_nxt = AW'(idx_r);
        end else begin
          fin        = 1'b1;
          fin_status = ifsa_pkg::ST_NOT_FREE;
        end
      end
      ifsa_pkg::S_MOVE: begin
        re        = 1'b1;
        raddr     = top_m1;
        state_nxt = ifsa_pkg::S_MOVE_WR;
      end
      ifsa_pkg::S_MOVE_WR: begin
        we      = 1'b1;
        waddr   = found_r;
        wdata   = rdata;
        top_nxt = top_r - CW'(1);
        fin     = 1'b1;
      end
      default: begin
        state_nxt = ifsa_pkg::S_IDLE;
      end
    endcase
    if (fin) begin
      state_nxt = ifsa_pkg::S_IDLE;
    end
    out_valid_nxt = fin ? 1'b1 : (out_valid_r && !out_tready);
    status_nxt    = fin ? fin_status : status_r;
    grant_nxt     = fin ? fin_grant : grant_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ifsa_pkg::S_INIT;
      top_r       <= CW'(MAX_ID);
      init_r      <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      top_r       <= top_nxt;
      init_r      <= init_nxt;
      pend_r      <= pend_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r    <= cmd_nxt;
    id_r     <= id_nxt;
    idx_r    <= idx_nxt;
    pidx_r   <= pidx_nxt;
    found_r  <= found_nxt;
    status_r <= status_nxt;
    grant_r  <= grant_nxt;
  end

  `IFSA_ASSERT_IMPL(a_top_bound, 1'b1, top_r <= CW'(MAX_ID), "stack count above depth")
  `IFSA_ASSERT_IMPL(a_grant_range,
                    out_valid_r && (status_r == ifsa_pkg::ST_OK),
                    grant_r <= IDW'(MAX_ID), "granted id out of range")
  `IFSA_ASSERT_IMPL(a_grant_zero,
                    out_valid_r && (status_r != ifsa_pkg::ST_OK),
                    grant_r == '0, "nonzero id on failed word")
  `IFSA_ASSERT_NEXT(a_pop_dec, state_r == ifsa_pkg::S_POP,
                    top_r == $past(top_r) - CW'(1), "pop did not shrink stack")

endmodule

[rtl/ifsa_ram.sv]
module ifsa_ram #(
  parameter int DEPTH = ifsa_pkg::MAX_ID_DEF,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [AW-1:0]            waddr,
  input  logic [ifsa_pkg::ID_W-1:0] wdata,
  input  logic                     re,
  input  logic [AW-1:0]            raddr,
  output logic [ifsa_pkg::ID_W-1:0] rdata
);

  logic [ifsa_pkg::ID_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
